// ----- src/mdfs_pkg.sv -----
// Shared types and constants for the maze walk step unit.
package mdfs_pkg;
	localparam int MaxRooms = 128;
	localparam int MaxDoors = 512;
	localparam int StackDepth = 128;
	localparam int RoomW = 8;
	localparam int DoorW = 9;
	localparam int CountW = 8;

	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_STEP = 2'd2;

	typedef struct packed {
		logic load;       // write door entry
		logic start;      // start walk
		logic clr_step;   // clear list, reset scan
		logic scan1_en;   // first scan active (issue reads)
		logic div_start;  // begin remainder
		logic pick;       // read chosen neighbour
		logic scan2_en;   // second scan active
		logic push;
		logic pop_rd;     // issue stack read
		logic pop_fin;    // apply popped room
		logic move;       // take chosen room
		logic finish;
		logic clear_res;  // clear result flags
		logic capture;    // load the output register
	} mdfs_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic match2;
		logic div_done;
		logic [CountW:0] count;
		logic active;
		logic stack_empty;
		logic stack_at_max;
	} mdfs_sts_t;
endpackage

// ----- src/mdfs_ram.sv -----
// Generic single-port-write, one-read RAM with registered read.
module mdfs_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

// ----- src/mdfs_datapath.sv -----
// Datapath: door table, visited map, neighbour list, stack, divider.
module mdfs_datapath import mdfs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  mdfs_cmd_t         cmd,
	input  logic [1:0]        op,
	input  logic [DoorW-1:0]  door_index,
	input  logic [RoomW-1:0]  room_a,
	input  logic [RoomW-1:0]  room_b,
	input  logic [15:0]       random_value,
	input  logic [RoomW-1:0]  room_count_q,
	output mdfs_sts_t         sts,
	output logic [RoomW-1:0]  cur_room,
	output logic              door_opened,
	output logic [DoorW-1:0]  opened_door,
	output logic              finished,
	output logic              stack_full
);
	logic [DoorW:0] door_total_q;
	logic [MaxRooms-1:0] visited_q;
	logic [RoomW-1:0] walk_room_q;
	logic active_q;
	logic [RoomW-1:0] sp_q;
	logic [CountW:0] count_q;
	logic [RoomW-1:0] chosen_q;
	logic opened_q, fin_q, full_q;
	logic [DoorW-1:0] door_at_q;

	// result held for the receiver while the next request runs
	logic [RoomW-1:0] res_room_q;
	logic res_opened_q, res_fin_q, res_full_q;
	logic [DoorW-1:0] res_door_q;

	// door table scan: address counter, registered read
	logic [DoorW:0] scan_q;
	logic rd_v_s1;
	logic [DoorW-1:0] rd_idx_s1;
	logic [15:0] door_rd;
	logic found_q;

	mdfs_ram #(.Width(16), .Depth(MaxDoors)) u_doors (
		.clk(clk), .we(cmd.load), .waddr(door_index), .wdata({room_a, room_b}),
		.raddr(scan_q[DoorW-1:0]), .rdata(door_rd)
	);

	// neighbour list as memory; dedup through a per-room seen bitmap
	logic [MaxRooms-1:0] seen_q;
	logic nl_we;
	logic [RoomW-1:0] nl_wdata, nl_rd;
	logic [$clog2(MaxRooms)-1:0] nl_raddr;
	mdfs_ram #(.Width(RoomW), .Depth(MaxRooms)) u_nlist (
		.clk(clk), .we(nl_we), .waddr(count_q[$clog2(MaxRooms)-1:0]), .wdata(nl_wdata),
		.raddr(nl_raddr), .rdata(nl_rd)
	);

	logic [RoomW-1:0] stk_rd;
	mdfs_ram #(.Width(RoomW), .Depth(StackDepth)) u_stack (
		.clk(clk), .we(cmd.push && sp_q < RoomW'(StackDepth)),
		.waddr(sp_q[$clog2(StackDepth)-1:0]), .wdata(walk_room_q),
		.raddr(sp_q[$clog2(StackDepth)-1:0]), .rdata(stk_rd)
	);

	// restoring remainder, one bit a cycle
	logic [15:0] div_n_q;
	logic [CountW:0] rem_q;
	logic [4:0] div_cnt_q;
	logic div_busy_q;
	logic [CountW+1:0] rem_sh;
	assign rem_sh = {rem_q, div_n_q[15]};
	// a single neighbour is always entry zero
	assign nl_raddr = (count_q == (CountW+1)'(1)) ? '0 : rem_q[$clog2(MaxRooms)-1:0];

	logic [RoomW-1:0] a_r, b_r, nb;
	logic hit, nb_ok, m2;
	always_comb begin
		a_r = door_rd[15:8];
		b_r = door_rd[7:0];
		hit = 1'b1;
		if (a_r == walk_room_q) nb = b_r;
		else if (b_r == walk_room_q) nb = a_r;
		else begin
			nb = '0;
			hit = 1'b0;
		end
		nb_ok = hit && nb != '0 && {1'b0, nb} <= 9'(MaxRooms)
			&& !visited_q[nb[6:0] - 7'd1] && !seen_q[nb[6:0] - 7'd1];
		nl_we = cmd.scan1_en && rd_v_s1 && nb_ok && count_q < (CountW+1)'(MaxRooms);
		nl_wdata = nb;
		m2 = cmd.scan2_en && rd_v_s1 && !found_q
			&& ((a_r == walk_room_q && b_r == chosen_q) || (b_r == walk_room_q && a_r == chosen_q));
	end

	logic [RoomW-1:0] rc;
	always_comb begin
		rc = room_count_q;
		if (rc == '0) rc = 8'd1;
		if (rc > 8'(MaxRooms)) rc = 8'(MaxRooms);
	end

	assign sts.scan_done = scan_q >= door_total_q && !rd_v_s1;
	assign sts.match2 = m2;
	assign sts.div_done = !div_busy_q;
	assign sts.count = count_q;
	assign sts.active = active_q;
	assign sts.stack_empty = sp_q == '0;
	assign sts.stack_at_max = sp_q >= RoomW'(StackDepth);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			door_total_q <= '0;
			visited_q <= '0;
			walk_room_q <= '0;
			active_q <= 1'b0;
			sp_q <= '0;
			count_q <= '0;
			scan_q <= '0;
			rd_v_s1 <= 1'b0;
			rd_idx_s1 <= '0;
			found_q <= 1'b0;
			seen_q <= '0;
			div_busy_q <= 1'b0;
			div_n_q <= '0;
			rem_q <= '0;
			div_cnt_q <= '0;
			chosen_q <= '0;
			door_at_q <= '0;
			opened_q <= 1'b0;
			fin_q <= 1'b0;
			full_q <= 1'b0;
			res_room_q <= '0;
			res_opened_q <= 1'b0;
			res_door_q <= '0;
			res_fin_q <= 1'b0;
			res_full_q <= 1'b0;
		end else begin
			if (cmd.clear_res) begin
				opened_q <= 1'b0;
				fin_q <= 1'b0;
				full_q <= 1'b0;
			end
			if (cmd.load && (DoorW+1)'(door_index) + 1'b1 > door_total_q)
				door_total_q <= (DoorW+1)'(door_index) + 1'b1;
			if (cmd.clr_step) begin
				count_q <= '0;
				seen_q <= '0;
				scan_q <= '0;
				rd_v_s1 <= 1'b0;
				found_q <= 1'b0;
			end
			if (cmd.scan1_en || cmd.scan2_en) begin
				rd_v_s1 <= scan_q < door_total_q;
				rd_idx_s1 <= scan_q[DoorW-1:0];
				if (scan_q < door_total_q) scan_q <= scan_q + 1'b1;
			end
			if (nl_we) begin
				count_q <= count_q + 1'b1;
				seen_q[nb[6:0] - 7'd1] <= 1'b1;
			end
			if (m2) begin
				found_q <= 1'b1;
				door_at_q <= rd_idx_s1;
				opened_q <= 1'b1;
			end
			if (cmd.div_start) begin
				div_busy_q <= 1'b1;
				div_cnt_q <= 5'd16;
				rem_q <= '0;
				div_n_q <= random_value;
			end else if (div_busy_q) begin
				// start uses divisor rc, step uses count
				if (op == OP_START) begin
					if (rem_sh >= (CountW+2)'(rc))
						rem_q <= (CountW+1)'(rem_sh - (CountW+2)'(rc));
					else rem_q <= rem_sh[CountW:0];
				end else begin
					if (rem_sh >= (CountW+2)'(count_q))
						rem_q <= (CountW+1)'(rem_sh - (CountW+2)'(count_q));
					else rem_q <= rem_sh[CountW:0];
				end
				div_n_q <= {div_n_q[14:0], 1'b0};
				div_cnt_q <= div_cnt_q - 1'b1;
				if (div_cnt_q == 5'd1) div_busy_q <= 1'b0;
			end
			if (cmd.start) begin
				visited_q <= {{(MaxRooms-1){1'b0}}, 1'b1} << rem_q[6:0];
				sp_q <= '0;
				walk_room_q <= RoomW'(rem_q) + 1'b1;
				active_q <= 1'b1;
			end
			if (cmd.pick) begin
				chosen_q <= nl_rd;
			end
			if (cmd.push) begin
				if (sp_q < RoomW'(StackDepth)) sp_q <= sp_q + 1'b1;
				else full_q <= 1'b1;
			end
			if (cmd.move && found_q) begin
				walk_room_q <= chosen_q;
				visited_q[chosen_q[6:0] - 7'd1] <= 1'b1;
			end
			if (cmd.pop_rd) sp_q <= sp_q - 1'b1;
			if (cmd.pop_fin) begin
				walk_room_q <= stk_rd;
				if (stk_rd != '0 && {1'b0, stk_rd} <= 9'(MaxRooms))
					visited_q[stk_rd[6:0] - 7'd1] <= 1'b1;
			end
			if (cmd.finish) begin
				fin_q <= 1'b1;
				active_q <= 1'b0;
			end
			if (cmd.capture) begin
				res_room_q <= walk_room_q;
				res_opened_q <= opened_q;
				res_door_q <= opened_q ? door_at_q : '0;
				res_fin_q <= fin_q;
				res_full_q <= full_q;
			end
		end
	end

	assign cur_room = res_room_q;
	assign door_opened = res_opened_q;
	assign opened_door = res_door_q;
	assign finished = res_fin_q;
	assign stack_full = res_full_q;
endmodule

// ----- src/mdfs_ctrl.sv -----
// Controller: sequences load, start and step requests.
module mdfs_ctrl import mdfs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] op,
	input  mdfs_sts_t  sts,
	output mdfs_cmd_t  cmd,
	output logic       out_valid,
	input  logic       out_ready
);
	typedef enum logic [3:0] {
		S_IDLE, S_SDIV, S_SCAN1, S_DIV, S_PICK_A, S_PICK_B, S_SCAN2,
		S_POP, S_POPW, S_OUT
	} state_t;
	state_t state_q;
	logic out_valid_q;

	logic acc, out_free;
	assign in_ready = state_q == S_IDLE;
	assign acc = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					cmd.clear_res = 1'b1;
					cmd.load = op == OP_LOAD;
					cmd.clr_step = op == OP_STEP;
					cmd.div_start = op == OP_START;
				end
			end
			S_SDIV: cmd.start = sts.div_done;
			S_SCAN1: begin
				cmd.scan1_en = 1'b1;
				if (sts.scan_done) begin
					cmd.div_start = sts.count > 9'd1;
					cmd.push = sts.count > 9'd1;
					cmd.pop_rd = sts.count == '0 && !sts.stack_empty;
					cmd.finish = sts.count == '0 && sts.stack_empty;
				end
			end
			S_DIV: ;
			S_PICK_A: ;
			// rewind the scan for the door search
			S_PICK_B: begin
				cmd.pick = 1'b1;
				cmd.clr_step = 1'b1;
			end
			S_SCAN2: begin
				cmd.scan2_en = 1'b1;
				cmd.move = sts.scan_done;
			end
			S_POP: ;
			S_POPW: cmd.pop_fin = 1'b1;
			S_OUT: cmd.capture = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_free) out_valid_q <= state_q == S_OUT;
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						if (op == OP_START) state_q <= S_SDIV;
						else if (op == OP_STEP && sts.active) state_q <= S_SCAN1;
						else state_q <= S_OUT;
					end
				end
				S_SDIV: if (sts.div_done) state_q <= S_OUT;
				S_SCAN1: begin
					if (sts.scan_done) begin
						if (sts.count > 9'd1) state_q <= S_DIV;
						else if (sts.count == 9'd1) state_q <= S_PICK_A;
						else if (!sts.stack_empty) state_q <= S_POP;
						else state_q <= S_OUT;
					end
				end
				S_DIV: if (sts.div_done) state_q <= S_PICK_A;
				S_PICK_A: state_q <= S_PICK_B;
				S_PICK_B: state_q <= S_SCAN2;
				S_SCAN2: if (sts.scan_done) state_q <= S_OUT;
				S_POP: state_q <= S_POPW;
				S_POPW: state_q <= S_OUT;
				S_OUT: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- src/maze_dfs_backtracker_step_unit.sv -----
// Top level of the maze walk step unit.
// Load goes straight to the output; start runs a serial remainder first. A step with
// several neighbours runs a door scan, a serial remainder, the pick, a second door scan
// and output; a single neighbour skips the remainder; a pop reads the stack after the scan.
// One request in flight; the next is taken in the cycle after the output register loads.
// Reset clears the walk, door count and visited map; room_count resets to 100.
module maze_dfs_backtracker_step_unit import mdfs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        opcode,
	input  logic [DoorW-1:0]  door_index,
	input  logic [RoomW-1:0]  room_a,
	input  logic [RoomW-1:0]  room_b,
	input  logic [15:0]       random_value,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [RoomW-1:0]  current_room,
	output logic              door_opened,
	output logic [DoorW-1:0]  opened_door,
	output logic              finished,
	output logic              stack_full,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [7:0]        cfg_data
);
	logic [RoomW-1:0] room_count_q;
	logic [1:0] op_q;
	logic [15:0] rnd_q;
	mdfs_cmd_t cmd;
	mdfs_sts_t sts;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			room_count_q <= 8'd100;
			op_q <= OP_LOAD;
		end else begin
			if (cfg_valid) room_count_q <= cfg_data;
			if (in_valid && in_ready) op_q <= opcode;
		end
	end
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) rnd_q <= random_value;
	end

	// step remainder starts after the scan, so feed the held random value
	mdfs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.op(opcode), .sts(sts), .cmd(cmd), .out_valid(out_valid), .out_ready(out_ready)
	);

	mdfs_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .op(op_q),
		.door_index(door_index), .room_a(room_a), .room_b(room_b),
		.random_value(cmd.load || (in_valid && in_ready) ? random_value : rnd_q),
		.room_count_q(room_count_q), .sts(sts), .cur_room(current_room),
		.door_opened(door_opened), .opened_door(opened_door), .finished(finished),
		.stack_full(stack_full)
	);
endmodule

// ----- verif/tb_maze_dfs_backtracker_step_unit.sv -----
// Testbench for the maze walk step unit: directed and random requests checked against a predictor.
`timescale 1ns / 1ps

module tb_maze_dfs_backtracker_step_unit;
	import mdfs_pkg::*;

	localparam logic [1:0] OP_BAD = 2'd3;
	localparam int WatchLimit = 20000;
	localparam int HoldCycles = 400;

	typedef struct packed {
		logic [RoomW-1:0] room;
		logic             opened;
		logic [DoorW-1:0] door;
		logic             fin;
		logic             full;
	} walk_result_t;

	logic clk, arst_n;
	logic in_valid, in_ready;
	logic [1:0] opcode;
	logic [DoorW-1:0] door_index;
	logic [RoomW-1:0] room_a, room_b;
	logic [15:0] random_value;
	logic out_valid, out_ready;
	logic [RoomW-1:0] current_room;
	logic door_opened;
	logic [DoorW-1:0] opened_door;
	logic finished, stack_full;
	logic cfg_valid, cfg_ready;
	logic [7:0] cfg_data;

	maze_dfs_backtracker_step_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .door_index(door_index), .room_a(room_a), .room_b(room_b),
		.random_value(random_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.current_room(current_room), .door_opened(door_opened), .opened_door(opened_door),
		.finished(finished), .stack_full(stack_full),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// predicted state of the walk
	logic [15:0] door_tab [0:MaxDoors-1];
	int door_cnt;
	bit visited [1:MaxRooms];
	logic [RoomW-1:0] bt_stack [0:StackDepth-1];
	int sp;
	logic [RoomW-1:0] walk_room;
	bit walk_on;
	logic [7:0] room_cfg;

	walk_result_t pending_q [$];
	int errors, sent_cnt, step_cnt, open_cnt, fin_cnt, idle_cyc;
	bit quiet, hold_req;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit room_ok(int r);
		return r >= 1 && r <= MaxRooms;
	endfunction

	task automatic predict_walk(input logic [1:0] op, input logic [DoorW-1:0] idx,
			input logic [RoomW-1:0] ra, input logic [RoomW-1:0] rb, input logic [15:0] rnd);
		walk_result_t res;
		int rc, cnt, nb, a, b, cur, chosen;
		int nbl [0:MaxRooms-1];
		bit seen;
		res = '0;
		if (op == OP_LOAD) begin
			door_tab[idx] = {ra, rb};
			if (idx + 1 > door_cnt) door_cnt = idx + 1;
		end else if (op == OP_START) begin
			rc = int'(room_cfg);
			if (rc < 1) rc = 1;
			if (rc > MaxRooms) rc = MaxRooms;
			foreach (visited[r]) visited[r] = 0;
			sp = 0;
			walk_room = RoomW'(rnd % rc + 1);
			visited[walk_room] = 1;
			walk_on = 1;
		end else if (op == OP_STEP && walk_on) begin
			step_cnt++;
			cnt = 0;
			cur = int'(walk_room);
			for (int i = 0; i < door_cnt; i++) begin
				a = int'(door_tab[i][15:8]);
				b = int'(door_tab[i][7:0]);
				if (a == cur) nb = b;
				else if (b == cur) nb = a;
				else continue;
				if (!room_ok(nb) || visited[nb]) continue;
				seen = 0;
				for (int k = 0; k < cnt; k++) if (nbl[k] == nb) seen = 1;
				if (!seen && cnt < MaxRooms) begin
					nbl[cnt] = nb;
					cnt++;
				end
			end
			if (cnt >= 1) begin
				if (cnt > 1) begin
					chosen = nbl[rnd % cnt];
					if (sp < StackDepth) begin
						bt_stack[sp] = RoomW'(cur);
						sp++;
					end else res.full = 1'b1;
				end else chosen = nbl[0];
				for (int i = 0; i < door_cnt; i++) begin
					a = int'(door_tab[i][15:8]);
					b = int'(door_tab[i][7:0]);
					if ((a == cur && b == chosen) || (b == cur && a == chosen)) begin
						res.opened = 1'b1;
						res.door = DoorW'(i);
						walk_room = RoomW'(chosen);
						visited[chosen] = 1;
						open_cnt++;
						break;
					end
				end
			end else if (sp > 0) begin
				sp--;
				walk_room = bt_stack[sp];
				visited[walk_room] = 1;
			end else begin
				res.fin = 1'b1;
				walk_on = 0;
				fin_cnt++;
			end
		end
		res.room = walk_room;
		pending_q = {pending_q, res};
	endtask

	task automatic send_req(input logic [1:0] op, input int idx, input int ra, input int rb,
			input int rnd);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		door_index <= DoorW'(idx);
		room_a <= RoomW'(ra);
		room_b <= RoomW'(rb);
		random_value <= 16'(rnd);
		do @(posedge clk); while (!in_ready);
		predict_walk(op, DoorW'(idx), RoomW'(ra), RoomW'(rb), 16'(rnd));
		sent_cnt++;
	endtask

	// hold the input, wait for every result, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (2 * door_cnt + 40) @(posedge clk);
	endtask

	task automatic write_rooms(input int v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= 8'(v);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		room_cfg = 8'(v);
	endtask

	task automatic walk_to_end(input int cap);
		int n;
		n = 0;
		while (walk_on && n < cap) begin
			send_req(OP_STEP, 0, 0, 0, $urandom);
			n++;
		end
		send_req(OP_STEP, $urandom, $urandom, $urandom, $urandom);
	endtask

	task automatic test_directed();
		send_req(OP_STEP, 0, 0, 0, 16'hffff);
		send_req(OP_BAD, 9'h1ff, 8'hff, 8'hff, 16'hffff);
		send_req(OP_LOAD, 0, 1, 2, 0);
		send_req(OP_LOAD, 1, 2, 128, 0);
		send_req(OP_LOAD, 2, 0, 255, 0);
		send_req(OP_LOAD, 3, 2, 2, 0);
		send_req(OP_LOAD, 4, 3, 1, 0);
		send_req(OP_LOAD, 5, 2, 1, 0);
		send_req(OP_LOAD, 6, 129, 3, 0);
		write_rooms(1);
		send_req(OP_START, 0, 0, 0, 16'hffff);
		walk_to_end(20);
		send_req(OP_STEP, 0, 0, 0, 0);
	endtask

	task automatic test_room_limits();
		int vals [4] = '{0, 255, 128, 2};
		foreach (vals[i]) begin
			write_rooms(vals[i]);
			send_req(OP_START, 0, 0, 0, $urandom);
			send_req(OP_START, 0, 0, 0, 16'hffff);
			walk_to_end(6);
		end
	endtask

	task automatic test_wide_table();
		write_rooms(16);
		for (int i = 0; i <= 256; i++)
			send_req(OP_LOAD, i, $urandom_range(1, 16), $urandom_range(1, 16), 0);
		send_req(OP_START, 0, 0, 0, $urandom);
		walk_to_end(12);
	endtask

	task automatic test_backpressure();
		drain();
		hold_req = ~hold_req;
		for (int i = 0; i < 6; i++)
			send_req(OP_START, 0, 0, 0, $urandom);
		drain();
	endtask

	task automatic test_random_walks(input int goal, input bit last);
		int rc, nd, base;
		base = sent_cnt;
		while (sent_cnt - base < goal) begin
			if (last && sent_cnt - base > goal - 80) quiet = 1'b1;
			rc = $urandom_range(2, 24);
			write_rooms(rc);
			nd = $urandom_range(1, 40);
			for (int i = 0; i < nd; i++) begin
				if ($urandom_range(0, 9) == 0)
					send_req(OP_LOAD, i, $urandom_range(0, 255), $urandom_range(0, 255), $urandom);
				else
					send_req(OP_LOAD, i, $urandom_range(1, rc), $urandom_range(1, rc), $urandom);
			end
			send_req(OP_START, 0, 0, 0, $urandom);
			while (walk_on) begin
				if ($urandom_range(0, 9) == 0)
					send_req(2'($urandom_range(0, 3)),
						$urandom_range(0, door_cnt > 511 ? 511 : door_cnt),
						$urandom_range(0, 255), $urandom_range(0, 255), $urandom);
				else
					send_req(OP_STEP, 0, 0, 0, $urandom);
			end
			send_req(OP_STEP, 0, 0, 0, $urandom);
		end
	endtask

	// result checker
	always @(posedge clk) begin
		walk_result_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (pending_q.size() == 0) begin
				$display("%0t: result with nothing pending, room %0d", $time, current_room);
				errors++;
			end else begin
				exp_r = pending_q.pop_front();
				if (current_room !== exp_r.room) begin
					$display("%0t: current_room expected %0d actual %0d", $time, exp_r.room,
						current_room);
					errors++;
				end
				if (door_opened !== exp_r.opened) begin
					$display("%0t: door_opened expected %0d actual %0d", $time, exp_r.opened,
						door_opened);
					errors++;
				end
				if (opened_door !== exp_r.door) begin
					$display("%0t: opened_door expected %0d actual %0d", $time, exp_r.door,
						opened_door);
					errors++;
				end
				if (finished !== exp_r.fin) begin
					$display("%0t: finished expected %0d actual %0d", $time, exp_r.fin, finished);
					errors++;
				end
				if (stack_full !== exp_r.full) begin
					$display("%0t: stack_full expected %0d actual %0d", $time, exp_r.full,
						stack_full);
					errors++;
				end
			end
		end
	end

	// receiver with random stalls and one long hold-off
	initial begin
		int hold_cnt, stall_cnt;
		bit hold_seen;
		hold_cnt = 0;
		stall_cnt = 0;
		hold_seen = 1'b0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_cnt = HoldCycles;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_ready <= 1'b0;
			end else if (stall_cnt > 0) begin
				stall_cnt--;
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				stall_cnt = $urandom_range(0, 12);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cyc <= 0;
		else
			idle_cyc <= idle_cyc + 1;
		if (idle_cyc > WatchLimit) begin
			$display("%0t: watchdog expired", $time);
			$display("tb_maze_dfs_backtracker_step_unit: errors");
			$finish;
		end
	end

	initial begin
		sent_cnt = 0;
		step_cnt = 0;
		open_cnt = 0;
		fin_cnt = 0;
		quiet = 1'b0;
		hold_req = 1'b0;
		door_cnt = 0;
		sp = 0;
		walk_room = '0;
		walk_on = 0;
		room_cfg = 8'd100;
		foreach (visited[r]) visited[r] = 0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		opcode <= OP_LOAD;
		door_index <= '0;
		room_a <= '0;
		room_b <= '0;
		random_value <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_room_limits();
		test_backpressure();
		test_random_walks(80, 1'b0);
		test_wide_table();
		test_random_walks(60, 1'b1);
		drain();
		repeat (100) @(posedge clk);
		$display("Covered %0d requests: %0d walk steps, %0d doors opened, %0d walks finished.",
			sent_cnt, step_cnt, open_cnt, fin_cnt);
		$display("Room count limits, out-of-range rooms, idle steps and a 257-door table were hit.");
		if (errors == 0 && pending_q.size() == 0)
			$display("tb_maze_dfs_backtracker_step_unit: clean");
		else
			$display("tb_maze_dfs_backtracker_step_unit: errors");
		$finish;
	end
endmodule
